// ===== rtl/srps_pkg.sv =====
// Package for the stepper ramp and pressure stop unit.
// Holds the command, cause and register codes and the payload and configuration types.
// Depends on nothing; every other file of the block but srps_chan_if imports it.
package srps_pkg;

   localparam int CSR_INDEX_WIDTH = 3;
   localparam int CSR_DATA_WIDTH  = 32;

   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_START_HALF_PERIOD  = 3'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_TARGET_HALF_PERIOD = 3'd1;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_RAMP_DECREMENT     = 3'd2;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_RAMP_PERIOD        = 3'd3;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_CHECK_PERIOD       = 3'd4;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_STEP_LIMIT         = 3'd5;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_SAFETY_PRESSURE    = 3'd6;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_GOAL_PRESSURE      = 3'd7;

   localparam logic [1:0] FUNC_START = 2'd0;
   localparam logic [1:0] FUNC_TICK  = 2'd1;
   localparam logic [1:0] FUNC_STOP  = 2'd2;

   localparam logic [1:0] CAUSE_NONE   = 2'd0;
   localparam logic [1:0] CAUSE_LIMIT  = 2'd1;
   localparam logic [1:0] CAUSE_SAFETY = 2'd2;
   localparam logic [1:0] CAUSE_GOAL   = 2'd3;

   localparam logic [15:0] PRESSURE_RESET = 16'hFFFF;

   typedef struct packed {
      logic [1:0]  func;
      logic        sample_valid;
      logic [15:0] pressure_sample;
   } req_payload_type;

   typedef struct packed {
      logic        step_pulse;
      logic [23:0] pulse_half_period_us;
      logic [31:0] steps_done;
      logic        is_running;
      logic [1:0]  end_cause;
      logic [15:0] latest_pressure;
   } rsp_payload_type;

   typedef struct packed {
      logic [23:0] start_half_period_us;
      logic [23:0] target_half_period_us;
      logic [15:0] ramp_decrement_us;
      logic [15:0] ramp_period_steps;
      logic [15:0] check_period_steps;
      logic [31:0] step_limit;
      logic [15:0] safety_pressure;
      logic [15:0] goal_pressure;
   } cfg_type;

endpackage

// ===== rtl/srps_chan_if.sv =====
// Valid/ready channel carrying one payload per transaction.
// The payload type is a parameter; the block uses the payload types of srps_pkg.
interface srps_chan_if #(parameter type payload_type = logic);
   logic        valid;
   logic        ready;
   payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

// ===== rtl/stepper_ramp_pressure_stop_unit.sv =====
// Stepper ramp and pressure stop unit: supervises a stepper-driven injection run.
// An accepted request passes through the input register and then the result register before its response is valid.
// Throughput is one request per cycle while responses are taken; a single pass through the next-state logic sets it.
// Synchronous active-high reset idles the run and restores the register defaults.
// Depends on srps_pkg, srps_chan_if, srps_csr and srps_core.
module stepper_ramp_pressure_stop_unit (
   input  logic                                 clock,
   input  logic                                 reset,
   srps_chan_if.sink                            req_chan,
   srps_chan_if.source                          rsp_chan,
   input  logic                                 csr_we,
   input  logic [srps_pkg::CSR_INDEX_WIDTH-1:0] csr_index,
   input  logic [srps_pkg::CSR_DATA_WIDTH-1:0]  csr_wdata
);
   import srps_pkg::*;

   cfg_type cfg;

   srps_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   srps_core u_core (
      .clock    (clock),
      .reset    (reset),
      .cfg      (cfg),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

endmodule

// ===== rtl/srps_csr.sv =====
// Configuration registers of the stepper ramp and pressure stop unit.
// Depends on srps_pkg for the register indexes and the configuration struct.
module srps_csr (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   csr_we,
   input  logic [srps_pkg::CSR_INDEX_WIDTH-1:0]   csr_index,
   input  logic [srps_pkg::CSR_DATA_WIDTH-1:0]    csr_wdata,
   output srps_pkg::cfg_type                      cfg
);
   import srps_pkg::*;

   cfg_type cfg_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.start_half_period_us  <= '0;
         cfg_ff.target_half_period_us <= '0;
         cfg_ff.ramp_decrement_us     <= '0;
         cfg_ff.ramp_period_steps     <= '0;
         cfg_ff.check_period_steps    <= '0;
         cfg_ff.step_limit            <= '0;
         cfg_ff.safety_pressure       <= PRESSURE_RESET;
         cfg_ff.goal_pressure         <= PRESSURE_RESET;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_START_HALF_PERIOD:  cfg_ff.start_half_period_us  <= csr_wdata[23:0];
            CSR_TARGET_HALF_PERIOD: cfg_ff.target_half_period_us <= csr_wdata[23:0];
            CSR_RAMP_DECREMENT:     cfg_ff.ramp_decrement_us     <= csr_wdata[15:0];
            CSR_RAMP_PERIOD:        cfg_ff.ramp_period_steps     <= csr_wdata[15:0];
            CSR_CHECK_PERIOD:       cfg_ff.check_period_steps    <= csr_wdata[15:0];
            CSR_STEP_LIMIT:         cfg_ff.step_limit            <= csr_wdata[31:0];
            CSR_SAFETY_PRESSURE:    cfg_ff.safety_pressure       <= csr_wdata[15:0];
            CSR_GOAL_PRESSURE:      cfg_ff.goal_pressure         <= csr_wdata[15:0];
            default: begin
            end
         endcase
      end
   end

   assign cfg = cfg_ff;

endmodule

// ===== rtl/srps_core.sv =====
// Run supervisor: input register, run state, next-state logic and result register.
// Depends on srps_pkg and on the srps_chan_if channel interface.
module srps_core (
   input  logic              clock,
   input  logic              reset,
   input  srps_pkg::cfg_type cfg,
   srps_chan_if.sink         req_chan,
   srps_chan_if.source       rsp_chan
);
   import srps_pkg::*;

   logic            in_valid_ff;
   req_payload_type in_data_ff;
   logic            out_valid_ff;
   rsp_payload_type out_data_ff;
   logic            advance;

   logic        active_ff,       active_in;
   logic [31:0] step_counter_ff, step_counter_in;
   logic [23:0] half_period_ff,  half_period_in;
   logic [15:0] ramp_phase_ff,   ramp_phase_in;
   logic [15:0] check_phase_ff,  check_phase_in;
   logic [15:0] held_pressure_ff, held_pressure_in;
   logic [1:0]  stop_cause_ff,   stop_cause_in;

   logic        pulse;
   logic [23:0] used_period;
   logic [16:0] ramp_next;
   logic [16:0] check_next;
   logic        ramp_fire;
   logic        check_fire;
   logic [24:0] ramp_floor;
   rsp_payload_type result;

   // The result register moves on when empty or when its transaction completes.
   assign advance        = !out_valid_ff || rsp_chan.ready;
   assign req_chan.ready = !in_valid_ff || advance;

   always_comb begin
      active_in        = active_ff;
      step_counter_in  = step_counter_ff;
      half_period_in   = half_period_ff;
      ramp_phase_in    = ramp_phase_ff;
      check_phase_in   = check_phase_ff;
      held_pressure_in = held_pressure_ff;
      stop_cause_in    = stop_cause_ff;
      pulse            = 1'b0;
      used_period      = '0;
      ramp_next        = {1'b0, ramp_phase_ff} + 17'd1;
      check_next       = {1'b0, check_phase_ff} + 17'd1;
      ramp_fire        = (cfg.ramp_period_steps != '0)
                         && (ramp_next >= {1'b0, cfg.ramp_period_steps});
      check_fire       = (cfg.check_period_steps != '0)
                         && (check_next >= {1'b0, cfg.check_period_steps});
      ramp_floor       = {1'b0, cfg.target_half_period_us}
                         + {9'd0, cfg.ramp_decrement_us};

      unique case (in_data_ff.func)
         FUNC_START: begin
            stop_cause_in    = CAUSE_NONE;
            held_pressure_in = '0;
            step_counter_in  = '0;
            ramp_phase_in    = '0;
            check_phase_in   = '0;
            half_period_in   = cfg.start_half_period_us;
            active_in        = 1'b1;
         end
         FUNC_TICK: begin
            if (active_ff) begin
               if (step_counter_ff >= cfg.step_limit) begin
                  stop_cause_in = CAUSE_LIMIT;
                  active_in     = 1'b0;
               end else begin
                  pulse           = 1'b1;
                  used_period     = half_period_ff;
                  step_counter_in = step_counter_ff + 32'd1;

                  if (cfg.ramp_period_steps != '0) begin
                     ramp_phase_in = ramp_fire ? 16'd0 : ramp_next[15:0];
                  end
                  if (ramp_fire) begin
                     if ({1'b0, half_period_ff} > ramp_floor) begin
                        half_period_in = half_period_ff
                                         - {8'd0, cfg.ramp_decrement_us};
                     end else begin
                        half_period_in = cfg.target_half_period_us;
                     end
                  end

                  if (cfg.check_period_steps != '0) begin
                     check_phase_in = check_fire ? 16'd0 : check_next[15:0];
                  end
                  if (check_fire && in_data_ff.sample_valid) begin
                     held_pressure_in = in_data_ff.pressure_sample;
                     priority if (in_data_ff.pressure_sample >= cfg.safety_pressure) begin
                        stop_cause_in = CAUSE_SAFETY;
                        active_in     = 1'b0;
                     end else if (in_data_ff.pressure_sample >= cfg.goal_pressure) begin
                        stop_cause_in = CAUSE_GOAL;
                        active_in     = 1'b0;
                     end else begin
                     end
                  end
               end
            end
         end
         FUNC_STOP: begin
            active_in = 1'b0;
         end
         default: begin
         end
      endcase

      result.step_pulse           = pulse;
      result.pulse_half_period_us = used_period;
      result.steps_done           = step_counter_in;
      result.is_running           = active_in;
      result.end_cause            = stop_cause_in;
      result.latest_pressure      = held_pressure_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff      <= 1'b0;
         out_valid_ff     <= 1'b0;
         active_ff        <= 1'b0;
         step_counter_ff  <= '0;
         half_period_ff   <= '0;
         ramp_phase_ff    <= '0;
         check_phase_ff   <= '0;
         held_pressure_ff <= '0;
         stop_cause_ff    <= CAUSE_NONE;
      end else begin
         if (req_chan.ready) begin
            in_valid_ff <= req_chan.valid;
         end
         if (advance) begin
            out_valid_ff <= in_valid_ff;
         end
         if (advance && in_valid_ff) begin
            active_ff        <= active_in;
            step_counter_ff  <= step_counter_in;
            half_period_ff   <= half_period_in;
            ramp_phase_ff    <= ramp_phase_in;
            check_phase_ff   <= check_phase_in;
            held_pressure_ff <= held_pressure_in;
            stop_cause_ff    <= stop_cause_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_chan.ready && req_chan.valid) begin
         in_data_ff <= req_chan.payload;
      end
      if (advance && in_valid_ff) begin
         out_data_ff <= result;
      end
   end

   assign rsp_chan.valid   = out_valid_ff;
   assign rsp_chan.payload = out_data_ff;

   // A result without a step carries a zero half-period.
   assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && !out_data_ff.step_pulse) |-> (out_data_ff.pulse_half_period_us == '0))
      else $error("srps_core: half-period reported without a step");

   // A processed start command leaves a fresh, running run behind.
   assert property (@(posedge clock) disable iff (reset)
      (advance && in_valid_ff && in_data_ff.func == FUNC_START)
      |=> (active_ff && step_counter_ff == '0 && stop_cause_ff == CAUSE_NONE))
      else $error("srps_core: start did not reset the run");

   // Other commands advance the step count by at most one.
   assert property (@(posedge clock) disable iff (reset)
      (advance && in_valid_ff && in_data_ff.func != FUNC_START)
      |=> (step_counter_ff == $past(step_counter_ff)
           || step_counter_ff == $past(step_counter_ff) + 32'd1))
      else $error("srps_core: step count jumped");

   // A held item in the input register is neither lost nor overwritten.
   assert property (@(posedge clock) disable iff (reset)
      (in_valid_ff && !advance) |=> (in_valid_ff && $stable(in_data_ff)))
      else $error("srps_core: stalled item lost");

   // An issued step is always counted, so the step count is never zero alongside it.
   assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && out_data_ff.step_pulse) |-> (out_data_ff.steps_done != '0))
      else $error("srps_core: step issued without being counted");

endmodule

// ===== tb/stepper_ramp_pressure_stop_unit_tb.sv =====
// Self-checking testbench for the stepper ramp and pressure stop unit: start, step tick and stop
// commands are driven and every response is compared with a cycle-free model of the run.
// Depends on srps_pkg, srps_chan_if and stepper_ramp_pressure_stop_unit.
module stepper_ramp_pressure_stop_unit_tb;
   import srps_pkg::*;

   localparam int CYCLE_LIMIT    = 200000;
   localparam int HOLDOFF_CYCLES = 300;
   localparam int SETTLE_CYCLES  = 6;
   localparam int PHASE_ITEMS    = 190;
   localparam logic [1:0] FUNC_UNUSED = 2'd3;

   logic                       clock;
   logic                       reset;
   logic                       csr_we;
   logic [CSR_INDEX_WIDTH-1:0] csr_index;
   logic [CSR_DATA_WIDTH-1:0]  csr_wdata;

   srps_chan_if #(.payload_type(req_payload_type)) req_if ();
   srps_chan_if #(.payload_type(rsp_payload_type)) rsp_if ();

   stepper_ramp_pressure_stop_unit i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_chan  (req_if),
      .rsp_chan  (rsp_if),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   req_payload_type pending_cmds[$];
   rsp_payload_type expected_status[$];
   rsp_payload_type want_status;
   rsp_payload_type got_status;

   cfg_type     model_cfg;
   logic        model_active;
   logic [31:0] model_steps;
   logic [23:0] model_half_period;
   logic [15:0] model_ramp_phase;
   logic [15:0] model_check_phase;
   logic [15:0] model_pressure;
   logic [1:0]  model_cause;

   int send_idle_pct  = 0;
   int recv_stall_pct = 0;
   bit holdoff_armed  = 1'b0;
   int holdoff_count  = 0;
   bit req_taken      = 1'b0;
   int items_queued   = 0;
   int results_seen   = 0;
   int mismatch_count = 0;
   int cycle_count    = 0;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   function automatic bit phase_advance(input logic [15:0] phase, input logic [15:0] period,
                                        output logic [15:0] next_phase);
      next_phase = phase;
      if (period == 16'd0) return 1'b0;
      if ({1'b0, phase} + 17'd1 >= {1'b0, period}) begin
         next_phase = '0;
         return 1'b1;
      end
      next_phase = phase + 16'd1;
      return 1'b0;
   endfunction

   function automatic rsp_payload_type predict_status(input req_payload_type cmd);
      rsp_payload_type st;
      logic [15:0]     next_phase;
      logic [24:0]     ramp_floor;
      bit              fire;
      st = '0;
      case (cmd.func)
         FUNC_START: begin
            model_cause       = CAUSE_NONE;
            model_pressure    = '0;
            model_steps       = '0;
            model_ramp_phase  = '0;
            model_check_phase = '0;
            model_half_period = model_cfg.start_half_period_us;
            model_active      = 1'b1;
         end
         FUNC_TICK: begin
            if (model_active) begin
               if (model_steps >= model_cfg.step_limit) begin
                  model_cause  = CAUSE_LIMIT;
                  model_active = 1'b0;
               end else begin
                  st.step_pulse           = 1'b1;
                  st.pulse_half_period_us = model_half_period;
                  model_steps             = model_steps + 32'd1;
                  fire = phase_advance(model_ramp_phase, model_cfg.ramp_period_steps, next_phase);
                  model_ramp_phase = next_phase;
                  if (fire) begin
                     ramp_floor = {1'b0, model_cfg.target_half_period_us}
                                  + {9'd0, model_cfg.ramp_decrement_us};
                     if ({1'b0, model_half_period} > ramp_floor)
                        model_half_period = model_half_period
                                            - {8'd0, model_cfg.ramp_decrement_us};
                     else
                        model_half_period = model_cfg.target_half_period_us;
                  end
                  fire = phase_advance(model_check_phase, model_cfg.check_period_steps,
                                       next_phase);
                  model_check_phase = next_phase;
                  if (fire && cmd.sample_valid) begin
                     model_pressure = cmd.pressure_sample;
                     if (model_pressure >= model_cfg.safety_pressure) begin
                        model_cause  = CAUSE_SAFETY;
                        model_active = 1'b0;
                     end else if (model_pressure >= model_cfg.goal_pressure) begin
                        model_cause  = CAUSE_GOAL;
                        model_active = 1'b0;
                     end
                  end
               end
            end
         end
         FUNC_STOP: begin
            model_active = 1'b0;
         end
         default: begin
         end
      endcase
      st.steps_done      = model_steps;
      st.is_running      = model_active;
      st.end_cause       = model_cause;
      st.latest_pressure = model_pressure;
      return st;
   endfunction

   task automatic check_field(input string name, input logic [31:0] exp_v,
                              input logic [31:0] act_v);
      if (act_v !== exp_v) begin
         $error("%s: expected 0x%0h, got 0x%0h", name, exp_v, act_v);
         mismatch_count++;
      end
   endtask

   // Driver: a transaction stays on the channel until it has been taken.
   always @(negedge clock) begin
      if (reset) begin
         req_if.valid   <= 1'b0;
         req_if.payload <= '0;
      end else if (!req_if.valid || req_taken) begin
         if (pending_cmds.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
            req_if.payload <= pending_cmds.pop_front();
            req_if.valid   <= 1'b1;
         end else begin
            req_if.valid <= 1'b0;
         end
      end
   end

   always @(negedge clock) begin
      if (reset) begin
         rsp_if.ready <= 1'b0;
      end else if (holdoff_armed && holdoff_count < HOLDOFF_CYCLES) begin
         rsp_if.ready <= 1'b0;
         holdoff_count++;
      end else begin
         rsp_if.ready <= ($urandom_range(99) >= recv_stall_pct);
      end
   end

   // Monitor: predicts on each accepted request and checks each accepted response.
   always @(posedge clock) begin
      if (reset) begin
         req_taken         = 1'b0;
         model_cfg         = '0;
         model_cfg.safety_pressure = PRESSURE_RESET;
         model_cfg.goal_pressure   = PRESSURE_RESET;
         model_active      = 1'b0;
         model_steps       = '0;
         model_half_period = '0;
         model_ramp_phase  = '0;
         model_check_phase = '0;
         model_pressure    = '0;
         model_cause       = CAUSE_NONE;
      end else begin
         req_taken = req_if.valid && req_if.ready;
         if (req_taken) expected_status.push_back(predict_status(req_if.payload));
         if (rsp_if.valid && rsp_if.ready) begin
            results_seen++;
            if (expected_status.size() == 0) begin
               $error("response transaction arrived with no expectation pending");
               mismatch_count++;
            end else begin
               want_status = expected_status.pop_front();
               got_status  = rsp_if.payload;
               check_field("step_pulse", 32'(want_status.step_pulse),
                           32'(got_status.step_pulse));
               check_field("pulse_half_period_us", 32'(want_status.pulse_half_period_us),
                           32'(got_status.pulse_half_period_us));
               check_field("steps_done", want_status.steps_done, got_status.steps_done);
               check_field("is_running", 32'(want_status.is_running),
                           32'(got_status.is_running));
               check_field("end_cause", 32'(want_status.end_cause), 32'(got_status.end_cause));
               check_field("latest_pressure", 32'(want_status.latest_pressure),
                           32'(got_status.latest_pressure));
            end
         end
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("stepper_ramp_pressure_stop_unit_tb: FAIL");
         $finish;
      end
   end

   task automatic write_reg(input logic [CSR_INDEX_WIDTH-1:0] idx,
                            input logic [CSR_DATA_WIDTH-1:0] data);
      @(negedge clock);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      case (idx)
         CSR_START_HALF_PERIOD:  model_cfg.start_half_period_us  = data[23:0];
         CSR_TARGET_HALF_PERIOD: model_cfg.target_half_period_us = data[23:0];
         CSR_RAMP_DECREMENT:     model_cfg.ramp_decrement_us     = data[15:0];
         CSR_RAMP_PERIOD:        model_cfg.ramp_period_steps     = data[15:0];
         CSR_CHECK_PERIOD:       model_cfg.check_period_steps    = data[15:0];
         CSR_STEP_LIMIT:         model_cfg.step_limit            = data;
         CSR_SAFETY_PRESSURE:    model_cfg.safety_pressure       = data[15:0];
         CSR_GOAL_PRESSURE:      model_cfg.goal_pressure         = data[15:0];
         default: begin
         end
      endcase
      @(negedge clock);
      csr_we <= 1'b0;
   endtask

   task automatic write_settings(input cfg_type c);
      write_reg(CSR_START_HALF_PERIOD, 32'(c.start_half_period_us));
      write_reg(CSR_TARGET_HALF_PERIOD, 32'(c.target_half_period_us));
      write_reg(CSR_RAMP_DECREMENT, 32'(c.ramp_decrement_us));
      write_reg(CSR_RAMP_PERIOD, 32'(c.ramp_period_steps));
      write_reg(CSR_CHECK_PERIOD, 32'(c.check_period_steps));
      write_reg(CSR_STEP_LIMIT, c.step_limit);
      write_reg(CSR_SAFETY_PRESSURE, 32'(c.safety_pressure));
      write_reg(CSR_GOAL_PRESSURE, 32'(c.goal_pressure));
   endtask

   function automatic logic [31:0] pick_value(input logic [31:0] top, input logic [31:0] low_top);
      case ($urandom_range(5))
         0: return 32'd0;
         1: return top;
         2, 3: return $urandom_range(low_top);
         default: return $urandom & top;
      endcase
   endfunction

   function automatic cfg_type pick_settings(input int style);
      cfg_type c;
      c = '0;
      if (style == 0) begin
         c.start_half_period_us  = 24'hFFFFFF;
         c.target_half_period_us = 24'd0;
         c.ramp_decrement_us     = 16'hFFFF;
         c.ramp_period_steps     = 16'd1;
         c.check_period_steps    = 16'hFFFF;
         c.step_limit            = 32'hFFFFFFFF;
         c.safety_pressure       = 16'hFFFF;
         c.goal_pressure         = 16'hFFFF;
      end else if (style == 1) begin
         c.target_half_period_us = 24'hFFFFFF;
         c.ramp_period_steps     = 16'd1;
         c.check_period_steps    = 16'd1;
         c.step_limit            = 32'd0;
      end else begin
         c.start_half_period_us  = 24'(pick_value(32'hFFFFFF, 3000));
         c.target_half_period_us = 24'(pick_value(32'hFFFFFF, 3000));
         c.ramp_decrement_us     = 16'(pick_value(32'hFFFF, 400));
         c.ramp_period_steps     = 16'(pick_value(32'hFFFF, 6));
         c.check_period_steps    = 16'(pick_value(32'hFFFF, 6));
         c.step_limit            = pick_value(32'hFFFFFFFF, 50);
         c.safety_pressure       = 16'(pick_value(32'hFFFF, 32'hFFFF));
         c.goal_pressure         = 16'(pick_value(32'hFFFF, 32'hFFFF));
      end
      return c;
   endfunction

   // Samples cluster around the two thresholds so that both ways of ending a run occur.
   function automatic logic [15:0] pick_sample();
      case ($urandom_range(4))
         0: return 16'($urandom);
         1: return model_cfg.goal_pressure + 16'($urandom_range(2)) - 16'd1;
         2: return model_cfg.safety_pressure + 16'($urandom_range(2)) - 16'd1;
         3: return 16'($urandom_range(model_cfg.goal_pressure));
         default: return $urandom_range(1) ? 16'hFFFF : 16'h0000;
      endcase
   endfunction

   task automatic queue_cmd(input logic [1:0] func, input logic valid, input logic [15:0] sample);
      req_payload_type cmd;
      cmd.func            = func;
      cmd.sample_valid    = valid;
      cmd.pressure_sample = sample;
      pending_cmds.push_back(cmd);
      items_queued++;
   endtask

   task automatic queue_random_traffic(input int count);
      int goal_count;
      int run_len;
      goal_count = items_queued + count;
      while (items_queued < goal_count) begin
         if ($urandom_range(99) < 88) begin
            queue_cmd(FUNC_START, 1'($urandom), 16'($urandom));
            run_len = $urandom_range(1, 40);
            repeat (run_len) begin
               case ($urandom_range(49))
                  0: queue_cmd(FUNC_STOP, 1'($urandom), 16'($urandom));
                  1: queue_cmd(FUNC_UNUSED, 1'($urandom), 16'($urandom));
                  2: queue_cmd(FUNC_START, 1'($urandom), 16'($urandom));
                  default: queue_cmd(FUNC_TICK, $urandom_range(99) < 75, pick_sample());
               endcase
            end
         end else begin
            queue_cmd(2'($urandom_range(3)), 1'($urandom), 16'($urandom));
         end
      end
   endtask

   task automatic wait_for_drain();
      while (results_seen != items_queued) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   initial begin
      cfg_type settings;
      int      ph;
      reset          = 1'b1;
      csr_we         = 1'b0;
      csr_index      = '0;
      csr_wdata      = '0;
      req_if.valid   = 1'b0;
      req_if.payload = '0;
      rsp_if.ready   = 1'b0;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      settings = '0;
      settings.start_half_period_us  = 24'd1000;
      settings.target_half_period_us = 24'd200;
      settings.ramp_decrement_us     = 16'd100;
      settings.ramp_period_steps     = 16'd2;
      settings.check_period_steps    = 16'd3;
      settings.step_limit            = 32'd8;
      settings.safety_pressure       = 16'd5000;
      settings.goal_pressure         = 16'd3000;
      write_settings(settings);

      // Idle commands, then a run that ends at the step limit.
      queue_cmd(FUNC_TICK, 1'b1, 16'hFFFF);
      queue_cmd(FUNC_UNUSED, 1'b0, 16'h0000);
      queue_cmd(FUNC_STOP, 1'b0, 16'h0000);
      queue_cmd(FUNC_START, 1'b0, 16'h0000);
      queue_cmd(FUNC_TICK, 1'b1, 16'hFFFF);
      queue_cmd(FUNC_TICK, 1'b0, 16'h0000);
      queue_cmd(FUNC_TICK, 1'b1, 16'd1234);
      queue_cmd(FUNC_TICK, 1'b1, 16'h0000);
      queue_cmd(FUNC_TICK, 1'b0, 16'h0000);
      queue_cmd(FUNC_TICK, 1'b0, 16'd4999);
      queue_cmd(FUNC_TICK, 1'b0, 16'h0000);
      queue_cmd(FUNC_TICK, 1'b0, 16'h0000);
      queue_cmd(FUNC_TICK, 1'b0, 16'h0000);
      // A run that reaches the goal pressure exactly.
      queue_cmd(FUNC_START, 1'b1, 16'hFFFF);
      queue_cmd(FUNC_TICK, 1'b0, 16'h0000);
      queue_cmd(FUNC_TICK, 1'b0, 16'h0000);
      queue_cmd(FUNC_TICK, 1'b1, 16'd3000);
      // A restart while running, then the safety threshold exactly.
      queue_cmd(FUNC_START, 1'b0, 16'h0000);
      queue_cmd(FUNC_TICK, 1'b0, 16'h0000);
      queue_cmd(FUNC_START, 1'b0, 16'h0000);
      queue_cmd(FUNC_TICK, 1'b0, 16'h0000);
      queue_cmd(FUNC_TICK, 1'b0, 16'h0000);
      queue_cmd(FUNC_TICK, 1'b1, 16'd5000);
      queue_cmd(FUNC_STOP, 1'b1, 16'hFFFF);
      queue_cmd(FUNC_UNUSED, 1'b1, 16'hFFFF);
      wait_for_drain();

      for (ph = 0; ph < 8; ph++) begin
         case (ph % 4)
            0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
            1: begin send_idle_pct = 77; recv_stall_pct = 0;  end
            2: begin send_idle_pct = 0;  recv_stall_pct = 77; end
            default: begin send_idle_pct = 15; recv_stall_pct = 15; end
         endcase
         write_settings(pick_settings(ph));
         queue_random_traffic(PHASE_ITEMS);
         wait_for_drain();
      end

      // The receiver holds off while the sender keeps offering, so the block backs up.
      send_idle_pct  = 0;
      recv_stall_pct = 0;
      write_settings(pick_settings(2));
      holdoff_armed = 1'b1;
      queue_random_traffic(150);
      wait_for_drain();

      if (mismatch_count == 0 && expected_status.size() == 0)
         $display("stepper_ramp_pressure_stop_unit_tb: PASS");
      else
         $display("stepper_ramp_pressure_stop_unit_tb: FAIL");
      $finish;
   end

endmodule

// ===== sim.f =====
rtl/srps_pkg.sv
rtl/srps_chan_if.sv
rtl/srps_csr.sv
rtl/srps_core.sv
rtl/stepper_ramp_pressure_stop_unit.sv
tb/stepper_ramp_pressure_stop_unit_tb.sv
